### rtl/lfc_pkg.sv
package lfc_pkg;

    // Fixed frame layout
    localparam int HEADER_BYTES   = 16;
    localparam int POS_SEQ_FIRST  = 1;
    localparam int POS_SEQ_LAST   = 4;
    localparam int POS_TYPE       = 5;
    localparam int POS_ACK_FIRST  = 6;
    localparam int POS_ACK_LAST   = 9;
    localparam int POS_SYN_A      = 10;
    localparam int POS_SYN_B      = 11;
    localparam int POS_SUM_FIRST  = 12;
    localparam int POS_SUM_LAST   = 13;
    localparam int POS_STX        = 14;

    // Control characters
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_SYN = 8'h16;

    localparam logic [31:0] SEQ_NONE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        EV_RESYNC   = 3'd0,
        EV_EOT      = 3'd1,
        EV_FORMAT   = 3'd2,
        EV_CHECKSUM = 3'd3,
        EV_ACCEPT   = 3'd4,
        EV_PAYLOAD  = 3'd5
    } lfc_kind_t;

    // One judged frame or chunk, handed from front to back
    typedef struct packed {
        lfc_kind_t   kind;
        logic [31:0] seq;
        logic        ack_req;
        logic        rel_valid;
        logic [31:0] rel_seq;
        logic        has_payload;
        logic        bank;
    } lfc_job_t;

    // Back end done reading a store bank
    typedef struct packed {
        logic valid;
        logic bank;
    } lfc_free_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_OUTCOME,
        BK_READ,
        BK_EMIT
    } lfc_back_state_t;

endpackage

### rtl/lfc_ram.sv
module lfc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lfc_front.sv
module lfc_front import lfc_pkg::*; #(
    parameter int FRAME_LEN   = 32,
    parameter int CHUNK_BYTES = 16,
    parameter int IDX_W       = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             q_full,
    output logic             q_push,
    output lfc_job_t         q_job,
    input  lfc_free_t        bank_free,
    output logic             wr_en,
    output logic [IDX_W:0]   wr_addr,
    output logic [7:0]       wr_data
);

    localparam logic [IDX_W-1:0] LAST_POS  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] CHUNK_POS = IDX_W'(CHUNK_BYTES - 1);
    localparam logic [IDX_W-1:0] PAY_FIRST = IDX_W'(HEADER_BYTES - 1);
    localparam bit               CHUNK_ON  = (CHUNK_BYTES <= FRAME_LEN);

    logic [IDX_W-1:0] cnt_reg;
    logic             bank_reg;
    logic [1:0]       busy_reg, busy_next;
    logic [7:0]       byte0_reg;
    logic             sync_reg, sync_next;
    logic             eot_reg, eot_next;
    logic             fmt_reg, fmt_next;
    logic             ackf_reg, ackf_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      acked_reg, acked_next;
    logic [15:0]      sent_reg, sent_next;
    logic [15:0]      sum_reg, sum_next;

    logic       accept, first, fmt_hit, chunk_hit, frame_end, push, rel;
    logic [7:0] byte0_eff;
    lfc_job_t   job;

    assign in_stall = q_full || busy_reg[bank_reg];
    assign accept   = in_valid && !in_stall;

    assign wr_en   = accept;
    assign wr_addr = {bank_reg, cnt_reg};
    assign wr_data = rx_byte;

    always_comb
    begin
        first     = (cnt_reg == '0);
        byte0_eff = first ? rx_byte : byte0_reg;
        sync_next = (first || sync_reg) && (rx_byte == BYTE_SYN);
        eot_next  = (first || eot_reg)
                    && (first || cnt_reg == LAST_POS || rx_byte == BYTE_EOT);

        if (first)
            fmt_hit = (rx_byte == BYTE_SOH);
        else if (cnt_reg == IDX_W'(POS_TYPE))
            fmt_hit = rx_byte inside {BYTE_ACK, BYTE_NAK};
        else if (cnt_reg == IDX_W'(POS_SYN_A) || cnt_reg == IDX_W'(POS_SYN_B))
            fmt_hit = (rx_byte == BYTE_SYN);
        else if (cnt_reg == IDX_W'(POS_STX))
            fmt_hit = (rx_byte == BYTE_STX);
        else
            fmt_hit = 1'b1;
        fmt_next = (first || fmt_reg) && fmt_hit;

        ackf_next = (cnt_reg == IDX_W'(POS_TYPE)) ? (rx_byte == BYTE_ACK) : ackf_reg;

        seq_next = seq_reg;
        if (cnt_reg >= IDX_W'(POS_SEQ_FIRST) && cnt_reg <= IDX_W'(POS_SEQ_LAST))
            seq_next = {seq_reg[23:0], rx_byte};
        acked_next = acked_reg;
        if (cnt_reg >= IDX_W'(POS_ACK_FIRST) && cnt_reg <= IDX_W'(POS_ACK_LAST))
            acked_next = {acked_reg[23:0], rx_byte};
        sent_next = sent_reg;
        if (cnt_reg >= IDX_W'(POS_SUM_FIRST) && cnt_reg <= IDX_W'(POS_SUM_LAST))
            sent_next = {sent_reg[7:0], rx_byte};

        if (first)
            sum_next = '0;
        else if (cnt_reg >= PAY_FIRST && cnt_reg < LAST_POS)
            sum_next = sum_reg + {8'd0, rx_byte};
        else
            sum_next = sum_reg;

        chunk_hit = CHUNK_ON && (cnt_reg == CHUNK_POS) && (byte0_eff != BYTE_SOH);
        frame_end = (cnt_reg == LAST_POS);

        // judge the chunk or the completed frame
        rel  = ackf_reg && (acked_reg != SEQ_NONE);
        job  = '0;
        job.bank = bank_reg;
        push = 1'b0;
        if (chunk_hit)
        begin
            job.kind = EV_RESYNC;
            push     = sync_next;
        end
        else if (frame_end)
        begin
            push = 1'b1;
            if (eot_next && byte0_reg == BYTE_SOH && rx_byte == BYTE_ETX)
                job.kind = EV_EOT;
            else if (!fmt_reg || rx_byte != BYTE_ETX)
                job.kind = EV_FORMAT;
            else if (sum_reg != sent_reg)
            begin
                job.kind = EV_CHECKSUM;
                job.seq  = seq_reg;
            end
            else
            begin
                job.kind        = EV_ACCEPT;
                job.seq         = seq_reg;
                job.ack_req     = (seq_reg != SEQ_NONE);
                job.rel_valid   = rel;
                job.rel_seq     = rel ? acked_reg : '0;
                job.has_payload = (seq_reg != SEQ_NONE);
            end
        end

        busy_next = busy_reg;
        if (bank_free.valid)
            busy_next[bank_free.bank] = 1'b0;
        if (accept && frame_end && !chunk_hit && job.has_payload)
            busy_next[bank_reg] = 1'b1;
    end

    assign q_push = accept && push;
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                cnt_reg <= (chunk_hit || frame_end) ? '0 : cnt_reg + 1'b1;
                if (frame_end && !chunk_hit && job.has_payload)
                    bank_reg <= !bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte0_reg <= byte0_eff;
            sync_reg  <= sync_next;
            eot_reg   <= eot_next;
            fmt_reg   <= fmt_next;
            ackf_reg  <= ackf_next;
            seq_reg   <= seq_next;
            acked_reg <= acked_next;
            sent_reg  <= sent_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

### rtl/lfc_queue.sv
module lfc_queue import lfc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lfc_job_t push_job,
    output logic     full,
    input  logic     pop,
    output lfc_job_t pop_job,
    output logic     empty
);

    lfc_job_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### rtl/lfc_back.sv
module lfc_back import lfc_pkg::*; #(
    parameter int PAYLOAD_BYTES = 16,
    parameter int IDX_W         = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  lfc_job_t       q_job,
    output logic           q_pop,
    output logic           rd_en,
    output logic [IDX_W:0] rd_addr,
    input  logic [7:0]     rd_data,
    output lfc_free_t      bank_free,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     event_kind,
    output logic [31:0]    frame_seq,
    output logic           ack_request,
    output logic           release_valid,
    output logic [31:0]    release_seq,
    output logic [7:0]     payload_data,
    output logic [35:0]    payload_addr,
    output logic           last
);

    localparam logic [IDX_W-1:0] PAY_FIRST = IDX_W'(HEADER_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_PAY  = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [5:0]       PAY_MUL   = 6'(PAYLOAD_BYTES);

    lfc_back_state_t state_reg, state_next;
    lfc_job_t        job_reg;
    logic [35:0]     base_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [35:0]     prod;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg;
    logic [31:0] seq_reg;
    logic        ackreq_reg, relv_reg, last_reg;
    logic [31:0] rels_reg;
    logic [7:0]  data_reg;
    logic [35:0] addr_reg;

    logic out_free, load_outcome, load_payload;

    assign out_free = !out_valid_reg || !out_stall;
    assign prod     = 36'(q_job.seq) * 36'(PAY_MUL);
    assign rd_addr  = {job_reg.bank, PAY_FIRST + idx_reg};

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        load_outcome = 1'b0;
        load_payload = 1'b0;
        bank_free    = '0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = BK_OUTCOME;
                end
            end
            BK_OUTCOME:
            begin
                if (out_free)
                begin
                    load_outcome = 1'b1;
                    idx_next     = '0;
                    state_next   = job_reg.has_payload ? BK_READ : BK_IDLE;
                end
            end
            BK_READ:
            begin
                rd_en      = 1'b1;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    load_payload = 1'b1;
                    if (idx_reg == LAST_PAY)
                    begin
                        bank_free.valid = 1'b1;
                        bank_free.bank  = job_reg.bank;
                        state_next      = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            default:
                state_next = BK_IDLE;
        endcase

        if (load_outcome || load_payload)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (q_pop)
        begin
            job_reg  <= q_job;
            base_reg <= prod;
        end
        if (load_outcome)
        begin
            kind_reg   <= job_reg.kind;
            seq_reg    <= job_reg.seq;
            ackreq_reg <= job_reg.ack_req;
            relv_reg   <= job_reg.rel_valid;
            rels_reg   <= job_reg.rel_seq;
            data_reg   <= '0;
            addr_reg   <= '0;
            last_reg   <= !job_reg.has_payload;
        end
        else if (load_payload)
        begin
            kind_reg   <= EV_PAYLOAD;
            seq_reg    <= job_reg.seq;
            ackreq_reg <= 1'b0;
            relv_reg   <= 1'b0;
            rels_reg   <= '0;
            data_reg   <= rd_data;
            addr_reg   <= base_reg + 36'(idx_reg);
            last_reg   <= (idx_reg == LAST_PAY);
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign frame_seq     = seq_reg;
    assign ack_request   = ackreq_reg;
    assign release_valid = relv_reg;
    assign release_seq   = rels_reg;
    assign payload_data  = data_reg;
    assign payload_addr  = addr_reg;
    assign last          = last_reg;

endmodule

### rtl/link_frame_checker_top.sv
// Link frame checker. Received link bytes come in one beat per byte on the
// in_valid/in_stall channel and are collected into frames of 16 + PAYLOAD_BYTES
// bytes (SOH, sequence, ACK/NAK, acked sequence, two SYN, checksum, STX,
// payload, ETX). When CHUNK_BYTES bytes have arrived and the first is not SOH,
// the group is judged: all SYN gives a resync beat, anything else is dropped.
// A full frame gives one outcome beat (end of transmission, format error,
// checksum error with the nack sequence, or accepted); an accepted frame whose
// sequence is not all ones is followed by one payload beat per payload byte,
// addressed seq * PAYLOAD_BYTES + offset (36-bit wrap). `last` marks the final
// beat caused by one input byte. Rate: the front takes one byte per cycle
// while in_stall is low; header fields, format flags and the checksum are
// folded in as bytes arrive, so the verdict is ready the cycle the final
// byte lands. The back takes one queued job at a time: it emits the outcome
// beat, then for each payload byte does a registered read of the frame store
// (BK_READ) and emits the beat (BK_EMIT). The store is double-banked and a
// two-entry job queue sits between front and back, so input stalls only when
// two judged items are pending, or the bank about to be written is still
// being drained. No clearing pass after reset.
module link_frame_checker_top import lfc_pkg::*; #(
    parameter int PAYLOAD_BYTES = 16,
    parameter int CHUNK_BYTES   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [31:0] frame_seq,
    output logic        ack_request,
    output logic        release_valid,
    output logic [31:0] release_seq,
    output logic [7:0]  payload_data,
    output logic [35:0] payload_addr,
    output logic        last
);

    localparam int FRAME_LEN = HEADER_BYTES + PAYLOAD_BYTES;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    // two banks of one frame each
    localparam int RAM_DEPTH = 2 * (1 << IDX_W);

    logic           q_push, q_full, q_pop, q_empty;
    lfc_job_t       push_job, pop_job;
    lfc_free_t      bank_free;
    logic           wr_en, rd_en;
    logic [IDX_W:0] wr_addr, rd_addr;
    logic [7:0]     wr_data, rd_data;

    // Front: byte collection and frame/chunk judgement
    lfc_front #(
        .FRAME_LEN   (FRAME_LEN),
        .CHUNK_BYTES (CHUNK_BYTES),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .bank_free (bank_free),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Frame store, written by the front, read back for payload beats
    lfc_ram #(
        .DATA_W (8),
        .DEPTH  (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // Back: outcome beat, then payload beats from the store when the job has payload
    lfc_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .bank_free     (bank_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_kind    (event_kind),
        .frame_seq     (frame_seq),
        .ack_request   (ack_request),
        .release_valid (release_valid),
        .release_seq   (release_seq),
        .payload_data  (payload_data),
        .payload_addr  (payload_addr),
        .last          (last)
    );

    // Job queue never takes a push while full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job queue overflow");

    // An accepted frame closes its input exactly when no payload follows
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == EV_ACCEPT) |-> (last == !ack_request))
        else $error("accepted beat last flag mismatch");

    // Only payload beats carry payload data or address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind != EV_PAYLOAD)
            |-> (payload_data == '0 && payload_addr == '0))
        else $error("payload fields set on non-payload beat");

    // Release only ever rides on an accepted frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && release_valid) |-> (event_kind == EV_ACCEPT))
        else $error("release on wrong beat kind");

endmodule
